[hdl/fbde_pkg.sv]
// ---------------------------------------------------------------------------
// fbde_pkg - shared constants and types of the framebuffer draw engine
// Screen geometry, store size, command codes and walker control words.
// ---------------------------------------------------------------------------
package fbde_pkg;

   localparam int SCREEN_W   = 128;
   localparam int SCREEN_H   = 64;
   localparam int FB_PAGES   = (SCREEN_H + 7) / 8;
   localparam int FB_BYTES   = SCREEN_W * FB_PAGES;
   localparam int ADDR_BITS  = $clog2(FB_BYTES);
   localparam int CNT_BITS   = ADDR_BITS + 1;
   localparam int POS_BITS   = 17;   // walk positions, signed
   localparam int ERR_BITS   = 21;   // Bresenham error term, signed

   typedef enum logic [2:0] {
      MODE_CLEAR  = 3'd0,
      MODE_FILL   = 3'd1,
      MODE_INVERT = 3'd2,
      MODE_PIXEL  = 3'd3,
      MODE_LINE   = 3'd4,
      MODE_RECT   = 3'd5,
      MODE_READ   = 3'd6,
      MODE_NONE   = 3'd7
   } mode_type;

   typedef struct packed {
      logic load_line;
      logic load_rect;
      logic advance;
   } walk_ctl_type;

   typedef struct packed {
      logic last;
      logic empty;
      logic on_screen;
   } walk_sts_type;

endpackage

[hdl/fbde_store.sv]
// ---------------------------------------------------------------------------
// fbde_store - frame store
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module fbde_store
   import fbde_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [7:0]           wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [7:0]           rd_data
);

   logic [7:0] mem [FB_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/fbde_walk.sv]
// ---------------------------------------------------------------------------
// fbde_walk - pixel walker
// Steps a Bresenham line or a clipped rectangle one pixel per advance.
// ---------------------------------------------------------------------------
module fbde_walk
   import fbde_pkg::*;
(
   input  logic                       clock,
   input  walk_ctl_type               ctl,
   input  logic signed [15:0]         xa,
   input  logic signed [15:0]         ya,
   input  logic signed [15:0]         xb,
   input  logic signed [15:0]         yb,
   input  logic [7:0]                 width,
   input  logic [7:0]                 height,
   output logic signed [POS_BITS-1:0] px,
   output logic signed [POS_BITS-1:0] py,
   output walk_sts_type               sts
);

   logic signed [POS_BITS-1:0] px_ff, py_ff, xe_ff, ye_ff, x0_ff;
   logic signed [POS_BITS-1:0] px_in, py_in, xe_in, ye_in, x0_in;
   logic signed [ERR_BITS-1:0] dx_ff, dy_ff, err_ff, dx_in, dy_in, err_in;
   logic                       stx_neg_ff, sty_neg_ff, line_ff, empty_ff;
   logic                       stx_neg_in, sty_neg_in, line_in, empty_in;

   logic signed [POS_BITS-1:0] xa_s, ya_s, xb_s, yb_s, ddx, ddy;
   logic signed [ERR_BITS-1:0] e2, adx, ady;
   logic [8:0]                 xsum, ysum;

   always_comb begin
      xa_s = POS_BITS'(xa);
      ya_s = POS_BITS'(ya);
      xb_s = POS_BITS'(xb);
      yb_s = POS_BITS'(yb);
      ddx  = xb_s - xa_s;
      ddy  = yb_s - ya_s;
      adx  = ddx[POS_BITS-1] ? -ERR_BITS'(ddx) : ERR_BITS'(ddx);
      ady  = ddy[POS_BITS-1] ? -ERR_BITS'(ddy) : ERR_BITS'(ddy);
      xsum = {1'b0, xa[7:0]} + {1'b0, width};
      ysum = {1'b0, ya[7:0]} + {1'b0, height};
      e2   = err_ff <<< 1;

      px_in = px_ff;  py_in = py_ff;  xe_in = xe_ff;  ye_in = ye_ff;
      x0_in = x0_ff;  dx_in = dx_ff;  dy_in = dy_ff;  err_in = err_ff;
      stx_neg_in = stx_neg_ff;  sty_neg_in = sty_neg_ff;
      line_in = line_ff;  empty_in = empty_ff;

      if (ctl.load_line) begin
         px_in = xa_s;  py_in = ya_s;  xe_in = xb_s;  ye_in = yb_s;
         dx_in = adx;  dy_in = -ady;  err_in = adx - ady;
         stx_neg_in = !(xa < xb);
         sty_neg_in = !(ya < yb);
         line_in = 1'b1;  empty_in = 1'b0;
      end else if (ctl.load_rect) begin
         px_in = POS_BITS'({1'b0, xa[7:0]});
         py_in = POS_BITS'({1'b0, ya[7:0]});
         x0_in = POS_BITS'({1'b0, xa[7:0]});
         xe_in = (xsum > 9'(SCREEN_W)) ? POS_BITS'(SCREEN_W - 1)
                                       : POS_BITS'(xsum) - POS_BITS'(1);
         ye_in = (ysum > 9'(SCREEN_H)) ? POS_BITS'(SCREEN_H - 1)
                                       : POS_BITS'(ysum) - POS_BITS'(1);
         line_in  = 1'b0;
         empty_in = (width == 8'd0) || (height == 8'd0) ||
                    ({1'b0, xa[7:0]} >= 9'(SCREEN_W)) ||
                    ({1'b0, ya[7:0]} >= 9'(SCREEN_H));
      end else if (ctl.advance) begin
         if (line_ff) begin
            err_in = err_ff + ((e2 >= dy_ff) ? dy_ff : '0)
                            + ((e2 <= dx_ff) ? dx_ff : '0);
            if (e2 >= dy_ff)
               px_in = stx_neg_ff ? px_ff - POS_BITS'(1) : px_ff + POS_BITS'(1);
            if (e2 <= dx_ff)
               py_in = sty_neg_ff ? py_ff - POS_BITS'(1) : py_ff + POS_BITS'(1);
         end else if (px_ff == xe_ff) begin
            px_in = x0_ff;
            py_in = py_ff + POS_BITS'(1);
         end else begin
            px_in = px_ff + POS_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;  py_ff <= py_in;  xe_ff <= xe_in;  ye_ff <= ye_in;
      x0_ff <= x0_in;  dx_ff <= dx_in;  dy_ff <= dy_in;  err_ff <= err_in;
      stx_neg_ff <= stx_neg_in;  sty_neg_ff <= sty_neg_in;
      line_ff <= line_in;  empty_ff <= empty_in;
   end

   assign px = px_ff;
   assign py = py_ff;
   assign sts.last      = (px_ff == xe_ff) && (py_ff == ye_ff);
   assign sts.empty     = empty_ff;
   assign sts.on_screen = !px_ff[POS_BITS-1] && !py_ff[POS_BITS-1] &&
                          (px_ff < POS_BITS'(SCREEN_W)) && (py_ff < POS_BITS'(SCREEN_H));

endmodule

[hdl/page_framebuffer_draw_engine_core.sv]
// ---------------------------------------------------------------------------
// page_framebuffer_draw_engine_core - monochrome page framebuffer engine
// Runs clear / fill / invert / pixel / line / rectangle / read commands on
// a page-major frame store, one result word per command.
// ---------------------------------------------------------------------------
//  channel | direction | words
//  req_*   | in        | one command word per accept
//  rsp_*   | out       | one read_data word per command
//
//  Whole-store commands sweep the store one byte a cycle, read and
//  write-back pipelined on the store's two ports. Pixel, line and rectangle
//  visit a read state and a modify-write state per on-screen pixel and
//  only the read state per off-screen line point. Read byte has an address and a data pass.
//  Every command then posts its result word from S_DONE.
//  After reset a clearing pass runs with req_ready low.
//  A result waits in an output register; the next command may be accepted
//  while it waits, but finishes only once the register frees.
module page_framebuffer_draw_engine_core
   import fbde_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic signed [15:0] req_coord_xa,
   input  logic signed [15:0] req_coord_ya,
   input  logic signed [15:0] req_coord_xb,
   input  logic signed [15:0] req_coord_yb,
   input  logic [7:0]         req_rect_width,
   input  logic [7:0]         req_rect_height,
   input  logic               req_ink,
   input  logic [9:0]         req_read_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_read_data
);

   typedef enum logic [6:0] {
      S_INIT   = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_SWEEP  = 7'b0000100,
      S_PIX_RD = 7'b0001000,
      S_PIX_WR = 7'b0010000,
      S_READ   = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   mode_type                op_ff, op_in;
   logic                    ink_ff, ink_in;
   logic [9:0]              ridx_ff, ridx_in;
   logic [7:0]              res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              out_data_ff, out_data_in;

   logic                    wr_en;
   logic [ADDR_BITS-1:0]    wr_addr, rd_addr, pix_addr;
   logic [7:0]              wr_data, rd_data, pix_mask;
   logic                    accept, out_free;

   walk_ctl_type               wctl;
   walk_sts_type               wsts;
   logic signed [POS_BITS-1:0] px, py;

   fbde_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // pixel commands go through the rectangle path as a 1x1 rectangle
   fbde_walk u_walk (
      .clock  (clock),
      .ctl    (wctl),
      .xa     (req_coord_xa),
      .ya     (req_coord_ya),
      .xb     (req_coord_xb),
      .yb     (req_coord_yb),
      .width  (mode_type'(req_mode) == MODE_PIXEL ? 8'd1 : req_rect_width),
      .height (mode_type'(req_mode) == MODE_PIXEL ? 8'd1 : req_rect_height),
      .px     (px),
      .py     (py),
      .sts    (wsts)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // byte index = page * width + column, bit = row within page
   assign pix_addr = ADDR_BITS'(ADDR_BITS'(py[POS_BITS-2:3]) * ADDR_BITS'(SCREEN_W)
                               + ADDR_BITS'(px[POS_BITS-2:0]));
   assign pix_mask = 8'd1 << py[2:0];

   always_comb begin
      state_in = state_ff;  cnt_in = cnt_ff;  op_in = op_ff;  ink_in = ink_ff;
      ridx_in = ridx_ff;  res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_data_in = out_data_ff;
      wr_en = 1'b0;
      wr_addr = pix_addr;
      wr_data = ink_ff ? (rd_data | pix_mask) : (rd_data & ~pix_mask);
      rd_addr = pix_addr;
      wctl = '0;

      unique case (state_ff)
         S_INIT, S_SWEEP: begin
            rd_addr = cnt_ff[ADDR_BITS-1:0];
            wr_en   = (cnt_ff != '0);
            wr_addr = ADDR_BITS'(cnt_ff - 1'b1);
            wr_data = (state_ff == S_INIT || op_ff == MODE_CLEAR) ? 8'h00 :
                      (op_ff == MODE_FILL) ? 8'hFF : ~rd_data;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(FB_BYTES)) begin
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in   = mode_type'(req_mode);
               ink_in  = req_ink;
               ridx_in = req_read_index;
               res_in  = 8'h00;
               cnt_in  = '0;
               unique case (mode_type'(req_mode))
                  MODE_CLEAR, MODE_FILL, MODE_INVERT: state_in = S_SWEEP;
                  MODE_PIXEL, MODE_RECT: begin
                     wctl.load_rect = 1'b1;
                     state_in = S_PIX_RD;
                  end
                  MODE_LINE: begin
                     wctl.load_line = 1'b1;
                     state_in = S_PIX_RD;
                  end
                  MODE_READ: state_in = S_READ;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_PIX_RD: begin
            if (wsts.empty) begin
               state_in = S_DONE;
            end else if (wsts.on_screen) begin
               state_in = S_PIX_WR;
            end else if (wsts.last) begin
               state_in = S_DONE;
            end else begin
               wctl.advance = 1'b1;
            end
         end
         S_PIX_WR: begin
            wr_en = 1'b1;
            if (wsts.last) begin
               state_in = S_DONE;
            end else begin
               wctl.advance = 1'b1;
               state_in = S_PIX_RD;
            end
         end
         S_READ: begin
            rd_addr = ridx_ff[ADDR_BITS-1:0];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               res_in   = ({22'd0, ridx_ff} < 32'(FB_BYTES)) ? rd_data : 8'h00;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      ink_ff      <= ink_in;
      ridx_ff     <= ridx_in;
      res_ff      <= res_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = out_data_ff;

endmodule

[hdl/fbde_check.sv]
// ---------------------------------------------------------------------------
// fbde_check - port checker for the draw engine
// Watches the handshakes seen at the top-level ports.
// ---------------------------------------------------------------------------
module fbde_check (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_read_data))
      else $error("result word changed while stalled");

   a_init_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("command taken during clearing pass");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken while one is running");

endmodule

bind page_framebuffer_draw_engine_core fbde_check u_fbde_check (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_read_data (rsp_read_data)
);

[bench/page_framebuffer_draw_engine_core_tb.sv]
// ---------------------------------------------------------------------------
// page_framebuffer_draw_engine_core_tb - self-checking bench of the draw engine
// A directed table, then random commands, go into the engine. A behavioural
// copy of the frame store predicts the read_data words the table omits. Both handshake
// sides idle at random. One long output stall and one drain pause are included.
// ---------------------------------------------------------------------------
module page_framebuffer_draw_engine_core_tb
   import fbde_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIMEOUT_CYCLES = 4_000_000;
   localparam int RANDOM_WORDS   = 560;
   localparam int STALL_CYCLES   = 3000;
   localparam int DRAIN_CYCLES   = 1100;   // a whole-store pass and a little more

   typedef struct {
      mode_type          mode;
      logic signed [15:0] xa, ya, xb, yb;
      logic [7:0]        w, h;
      logic              ink;
      logic [9:0]        idx;
      bit                typed;   // expected word given in the table
      logic [7:0]        typed_val;
   } draw_cmd_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_mode = MODE_NONE;
   logic signed [15:0] req_coord_xa = '0;
   logic signed [15:0] req_coord_ya = '0;
   logic signed [15:0] req_coord_xb = '0;
   logic signed [15:0] req_coord_yb = '0;
   logic [7:0]         req_rect_width = '0;
   logic [7:0]         req_rect_height = '0;
   logic               req_ink = 1'b0;
   logic [9:0]         req_read_index = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_read_data;

   logic [7:0]   shadow_store [FB_BYTES];   // predicted contents of the frame store
   logic [7:0]   pending_bytes [$];         // read_data words still owed
   draw_cmd_type directed_rows [$];
   int           mismatches = 0;
   int           cycle_count = 0;
   bit           quiet = 1'b0;              // no idling on either side
   logic         stall_arm = 1'b0;          // ask the receiver for its long hold-off

   page_framebuffer_draw_engine_core uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("page_framebuffer_draw_engine_core: mismatch");
         $finish;
      end
   end

   // ---- predictor -------------------------------------------------------
   function automatic void shadow_plot(int x, int y, logic ink);
      int idx;
      if (x < 0 || y < 0 || x >= SCREEN_W || y >= SCREEN_H) return;
      idx = (y >> 3) * SCREEN_W + x;
      if (ink) shadow_store[idx][y & 7] = 1'b1;
      else     shadow_store[idx][y & 7] = 1'b0;
   endfunction

   // Bresenham walk over the whole path, off-screen points simply dropped
   function automatic void shadow_line(int xa, int ya, int xb, int yb, logic ink);
      int dx, dy, sx, sy, err, e2;
      dx = (xb > xa) ? xb - xa : xa - xb;
      dy = (yb > ya) ? ya - yb : yb - ya;
      sx = (xa < xb) ? 1 : -1;
      sy = (ya < yb) ? 1 : -1;
      err = dx + dy;
      forever begin
         shadow_plot(xa, ya, ink);
         if (xa == xb && ya == yb) break;
         e2 = err * 2;
         if (e2 >= dy) begin
            err += dy;
            xa += sx;
         end
         if (e2 <= dx) begin
            err += dx;
            ya += sy;
         end
      end
   endfunction

   function automatic void shadow_rect(int x, int y, int w, int h, logic ink);
      if (w == 0 || h == 0 || x >= SCREEN_W || y >= SCREEN_H) return;
      if (x + w > SCREEN_W) w = SCREEN_W - x;
      if (y + h > SCREEN_H) h = SCREEN_H - y;
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++)
            shadow_plot(x + c, y + r, ink);
   endfunction

   // Applies one command to the shadow store and returns the word it yields
   function automatic logic [7:0] predict_read_data(draw_cmd_type c);
      logic [7:0] word_out;
      word_out = 8'h00;
      case (c.mode)
         MODE_CLEAR:  foreach (shadow_store[i]) shadow_store[i] = 8'h00;
         MODE_FILL:   foreach (shadow_store[i]) shadow_store[i] = 8'hFF;
         MODE_INVERT: foreach (shadow_store[i]) shadow_store[i] = ~shadow_store[i];
         MODE_PIXEL:  shadow_plot(int'(c.xa[7:0]), int'(c.ya[7:0]), c.ink);
         MODE_LINE:   shadow_line(int'(c.xa), int'(c.ya), int'(c.xb), int'(c.yb), c.ink);
         MODE_RECT:   shadow_rect(int'(c.xa[7:0]), int'(c.ya[7:0]),
                                  int'(c.w), int'(c.h), c.ink);
         MODE_READ:   if (c.idx < FB_BYTES) word_out = shadow_store[c.idx];
         default:     word_out = 8'h00;
      endcase
      return word_out;
   endfunction

   // ---- stimulus helpers ------------------------------------------------
   function automatic draw_cmd_type mk(mode_type m, int xa, int ya, int xb, int yb,
                                        int w, int h, bit ink, int idx,
                                        bit typed = 0, int val = 0);
      draw_cmd_type c;
      c.mode = m;
      c.xa = 16'(xa);
      c.ya = 16'(ya);
      c.xb = 16'(xb);
      c.yb = 16'(yb);
      c.w = 8'(w);
      c.h = 8'(h);
      c.ink = ink;
      c.idx = 10'(idx);
      c.typed = typed;
      c.typed_val = 8'(val);
      return c;
   endfunction

   function automatic draw_cmd_type random_cmd();
      draw_cmd_type c;
      int pick;
      c = mk(MODE_NONE, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, 1'($urandom), $urandom);
      pick = $urandom_range(99);
      if      (pick < 4)  c.mode = MODE_CLEAR;
      else if (pick < 8)  c.mode = MODE_FILL;
      else if (pick < 12) c.mode = MODE_INVERT;
      else if (pick < 37) c.mode = MODE_PIXEL;
      else if (pick < 62) c.mode = MODE_LINE;
      else if (pick < 75) c.mode = MODE_RECT;
      else if (pick < 97) c.mode = MODE_READ;
      else                c.mode = MODE_NONE;
      case (c.mode)
         MODE_PIXEL: begin
            // upper bits stay random, low byte mostly near the screen
            c.xa[7:0] = 8'($urandom_range(140));
            c.ya[7:0] = 8'($urandom_range(75));
         end
         MODE_LINE: begin
            // long lines walk every off-screen point, so keep them rare
            if ($urandom_range(99) != 0) begin
               c.xa = 16'(int'($urandom_range(170)) - 20);
               c.ya = 16'(int'($urandom_range(100)) - 20);
               c.xb = 16'(int'($urandom_range(170)) - 20);
               c.yb = 16'(int'($urandom_range(100)) - 20);
            end
         end
         MODE_RECT: begin
            c.xa[7:0] = 8'($urandom_range(135));
            c.ya[7:0] = 8'($urandom_range(70));
            if ($urandom_range(9) != 0) begin
               c.w = 8'($urandom_range(40));
               c.h = 8'($urandom_range(24));
            end
         end
         default: ;
      endcase
      return c;
   endfunction

   // Offers one command word and waits for it to be taken
   task automatic send_cmd(draw_cmd_type c);
      logic [7:0] predicted;
      if (!quiet && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= c.mode;
      req_coord_xa    <= c.xa;
      req_coord_ya    <= c.ya;
      req_coord_xb    <= c.xb;
      req_coord_yb    <= c.yb;
      req_rect_width  <= c.w;
      req_rect_height <= c.h;
      req_ink         <= c.ink;
      req_read_index  <= c.idx;
      do @(posedge clock); while (!req_ready);
      predicted = predict_read_data(c);
      pending_bytes.push_back(c.typed ? c.typed_val : predicted);
   endtask

   // ---- result side -----------------------------------------------------
   int         stall_left = 0;
   bit         stall_done = 1'b0;
   logic [7:0] want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_bytes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word read_data=%02h", rsp_read_data);
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_read_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("read_data: expected %02h, got %02h", want, rsp_read_data);
               end
            end
         end
         // long hold-off so the engine backs up into its input
         if (stall_arm && !stall_done) begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= 28);
         end
      end
   end

   // ---- main sequence ---------------------------------------------------
   initial begin
      foreach (shadow_store[i]) shadow_store[i] = 8'h00;

      // after reset, extremes, unused mode, clipping cases
      directed_rows.push_back(mk(MODE_READ,   0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00));
      directed_rows.push_back(mk(MODE_FILL,   0, 0, 0, 0, 0, 0, 1, 0));
      directed_rows.push_back(mk(MODE_READ,   0, 0, 0, 0, 0, 0, 0, 1023, 1, 8'hFF));
      directed_rows.push_back(mk(MODE_NONE,   -1, -1, -1, -1, 255, 255, 1, 1023, 1, 8'h00));
      directed_rows.push_back(mk(MODE_INVERT, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk(MODE_READ,   0, 0, 0, 0, 0, 0, 0, 5, 1, 8'h00));
      directed_rows.push_back(mk(MODE_PIXEL,  127, 63, 0, 0, 0, 0, 1, 0));
      directed_rows.push_back(mk(MODE_READ,   0, 0, 0, 0, 0, 0, 0, 1023, 1, 8'h80));
      directed_rows.push_back(mk(MODE_PIXEL,  16'hFF00, 16'h7F00, 0, 0, 0, 0, 1, 0));
      directed_rows.push_back(mk(MODE_PIXEL,  200, 10, 0, 0, 0, 0, 1, 0));
      directed_rows.push_back(mk(MODE_LINE,   5, 5, 5, 5, 0, 0, 1, 0));
      directed_rows.push_back(mk(MODE_LINE,   0, 9, 127, 9, 0, 0, 1, 0));
      directed_rows.push_back(mk(MODE_LINE,   40, 0, 40, 63, 0, 0, 1, 0));
      directed_rows.push_back(mk(MODE_LINE,   -10, -10, 140, 70, 0, 0, 1, 0));
      directed_rows.push_back(mk(MODE_LINE,   -32768, -32768, 32767, 32767, 0, 0, 0, 0));
      directed_rows.push_back(mk(MODE_READ,   0, 0, 0, 0, 0, 0, 0, 137));
      directed_rows.push_back(mk(MODE_RECT,   130, 0, 0, 0, 10, 10, 1, 0));
      directed_rows.push_back(mk(MODE_RECT,   3, 3, 0, 0, 0, 10, 1, 0));
      directed_rows.push_back(mk(MODE_RECT,   100, 50, 0, 0, 255, 255, 1, 0));
      directed_rows.push_back(mk(MODE_RECT,   110, 52, 0, 0, 4, 3, 0, 0));
      directed_rows.push_back(mk(MODE_READ,   0, 0, 0, 0, 0, 0, 0, 7 * 128 + 111));
      directed_rows.push_back(mk(MODE_READ,   0, 0, 0, 0, 0, 0, 1, 9));
      directed_rows.push_back(mk(MODE_CLEAR,  0, 0, 0, 0, 0, 0, 1, 0));
      directed_rows.push_back(mk(MODE_READ,   0, 0, 0, 0, 0, 0, 0, 1023, 1, 8'h00));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_cmd(directed_rows[i]);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         quiet = (n >= 150 && n < 230);
         if (n == 300) stall_arm <= 1'b1;
         if (n == 450) begin
            // sender pauses until every owed word is back
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_bytes.size() != 0);
         end
         send_cmd(random_cmd());
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      do @(posedge clock); while (pending_bytes.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_bytes.size() == 0) begin
         $display("page_framebuffer_draw_engine_core: match");
      end else begin
         $display("page_framebuffer_draw_engine_core: mismatch");
      end
      $finish;
   end

endmodule
